// File: sv/spc_pkg.sv
// shared types, constants and table builders for the stereo peak compressor
package spc_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 24;
    localparam int TABLE_INDEX_BITS_DEF = 8;

    // threshold 0.25 in q3.20 is 2^18
    localparam int          THRESH_LOG   = 18;
    localparam logic [31:0] THRESH_LEVEL = 32'd1 << THRESH_LOG;

    // multiplier b operand: unsigned, wide enough for 2^24
    localparam int MAC_B_W = 25;

    // apb register map
    localparam int          CFG_AW = 5;
    localparam logic [2:0]  REG_COMP_ENABLE   = 3'd0;
    localparam logic [2:0]  REG_COMP_SLOPE    = 3'd1;
    localparam logic [2:0]  REG_MAKEUP_GAIN   = 3'd2;
    localparam logic [2:0]  REG_ATTACK_COEFF  = 3'd3;
    localparam logic [2:0]  REG_RELEASE_COEFF = 3'd4;
    localparam logic [2:0]  REG_DRY_WET_MIX   = 3'd5;
    localparam logic [2:0]  REG_OUTPUT_GAIN   = 3'd6;

    localparam logic [15:0] RST_COMP_SLOPE    = 16'd0;
    localparam logic [23:0] RST_MAKEUP_GAIN   = 24'd4194304;
    localparam logic [23:0] RST_ATTACK_COEFF  = 24'd16707456;
    localparam logic [23:0] RST_RELEASE_COEFF = 24'd16773721;
    localparam logic [16:0] RST_DRY_WET_MIX   = 17'd65536;
    localparam logic [23:0] RST_OUTPUT_GAIN   = 24'd1048576;

    typedef struct packed {
        logic        comp_enable;
        logic [15:0] comp_slope;
        logic [23:0] makeup_gain;
        logic [23:0] attack_coeff;
        logic [23:0] release_coeff;
        logic [16:0] dry_wet_mix;
        logic [23:0] output_gain;
    } t_cfg;

    typedef struct packed {
        logic       en;
        logic       load;
        logic [4:0] bias_pos;
    } t_mac_ctl;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PEAK,
        S_ENV_A,
        S_ENV_B,
        S_ENV_WB,
        S_NORM,
        S_LOG_RD,
        S_LOG_SUM,
        S_RED_MUL,
        S_RED_WB,
        S_EXP_RD,
        S_GAIN,
        S_TG_MUL,
        S_TG_WB,
        S_SCL_MUL,
        S_SCL_WB,
        S_MIX_A,
        S_MIX_B,
        S_MIX_WB,
        S_OG_MUL,
        S_OG_WB,
        S_DONE
    } t_state;

    function automatic int mac_a_width(input int w);
        return (w + 4 > 24) ? w + 4 : 24;
    endfunction

    function automatic int mac_acc_width(input int w);
        return mac_a_width(w) + MAC_B_W + 3;
    endfunction

    // truncated log2 fraction of a q1.16 value in [1,2), by repeated squaring
    function automatic logic [15:0] log2_frac(input logic [16:0] y);
        logic [63:0] m;
        logic [15:0] r;
        int          k;
        m = {47'd0, y} << 14;
        r = '0;
        for (k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = {r[14:0], 1'b0};
            if (m >= (64'd2 << 30)) begin
                r[0] = 1'b1;
                m    = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] log_entry(input int i, input int tib);
        return log2_frac(17'(65536 + (i << (16 - tib))));
    endfunction

    // largest mantissa whose log does not exceed the table point
    function automatic logic [15:0] exp_entry(input int i, input int tib);
        int lo;
        int hi;
        int mid;
        int target;
        target = i << (16 - tib);
        lo     = 65536;
        hi     = 131071;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (int'(log2_frac(17'(mid))) <= target) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return 16'(lo - 65536);
    endfunction

endpackage

// File: sv/spc_regs.sv
// apb configuration registers of the stereo peak compressor
module spc_regs import spc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.comp_enable   <= 1'b0;
            r_cfg.comp_slope    <= RST_COMP_SLOPE;
            r_cfg.makeup_gain   <= RST_MAKEUP_GAIN;
            r_cfg.attack_coeff  <= RST_ATTACK_COEFF;
            r_cfg.release_coeff <= RST_RELEASE_COEFF;
            r_cfg.dry_wet_mix   <= RST_DRY_WET_MIX;
            r_cfg.output_gain   <= RST_OUTPUT_GAIN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COMP_ENABLE:   r_cfg.comp_enable   <= pwdata[0];
                REG_COMP_SLOPE:    r_cfg.comp_slope    <= pwdata[15:0];
                REG_MAKEUP_GAIN:   r_cfg.makeup_gain   <= pwdata[23:0];
                REG_ATTACK_COEFF:  r_cfg.attack_coeff  <= pwdata[23:0];
                REG_RELEASE_COEFF: r_cfg.release_coeff <= pwdata[23:0];
                REG_DRY_WET_MIX:   r_cfg.dry_wet_mix   <= pwdata[16:0];
                REG_OUTPUT_GAIN:   r_cfg.output_gain   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COMP_ENABLE:   prdata = {31'd0, r_cfg.comp_enable};
            REG_COMP_SLOPE:    prdata = {16'd0, r_cfg.comp_slope};
            REG_MAKEUP_GAIN:   prdata = {8'd0, r_cfg.makeup_gain};
            REG_ATTACK_COEFF:  prdata = {8'd0, r_cfg.attack_coeff};
            REG_RELEASE_COEFF: prdata = {8'd0, r_cfg.release_coeff};
            REG_DRY_WET_MIX:   prdata = {15'd0, r_cfg.dry_wet_mix};
            REG_OUTPUT_GAIN:   prdata = {8'd0, r_cfg.output_gain};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: sv/spc_mac.sv
// shared signed multiply-accumulate unit with a power-of-two rounding bias
module spc_mac import spc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  t_mac_ctl                                i_ctl,
    input  logic [mac_a_width(SAMPLE_WIDTH)-1:0]    i_a,
    input  logic [MAC_B_W-1:0]                      i_b,
    output logic [mac_acc_width(SAMPLE_WIDTH)-1:0]  o_acc
);

    localparam int A_W   = mac_a_width(SAMPLE_WIDTH);
    localparam int ACC_W = mac_acc_width(SAMPLE_WIDTH);
    localparam int P_W   = A_W + MAC_B_W + 1;

    logic signed [P_W-1:0]   prod;
    logic        [ACC_W-1:0] prod_ext;
    logic        [ACC_W-1:0] bias;
    logic        [ACC_W-1:0] r_acc;

    // a is signed, b is unsigned
    assign prod     = $signed(i_a) * $signed({1'b0, i_b});
    assign prod_ext = {{(ACC_W-P_W){prod[P_W-1]}}, prod};
    assign bias     = ACC_W'(1) << i_ctl.bias_pos;
    assign o_acc    = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= (i_ctl.load ? bias : r_acc) + prod_ext;
        end
    end

endmodule

// File: sv/spc_rom.sv
// log2 and exp2 mantissa tables with registered read
module spc_rom import spc_pkg::*; #(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic [TABLE_INDEX_BITS-1:0] i_log_addr,
    input  logic [TABLE_INDEX_BITS-1:0] i_exp_addr,
    output logic [15:0]                 o_log_q,
    output logic [15:0]                 o_exp_q
);

    localparam int TAB_SIZE = 1 << TABLE_INDEX_BITS;

    logic [15:0] log_tab [TAB_SIZE];
    logic [15:0] exp_tab [TAB_SIZE];

    for (genvar i = 0; i < TAB_SIZE; i++) begin : g_tab
        localparam logic [15:0] LOG_V = log_entry(i, TABLE_INDEX_BITS);
        localparam logic [15:0] EXP_V = exp_entry(i, TABLE_INDEX_BITS);
        assign log_tab[i] = LOG_V;
        assign exp_tab[i] = EXP_V;
    end

    always_ff @(posedge i_clk) begin
        o_log_q <= log_tab[i_log_addr];
        o_exp_q <= exp_tab[i_exp_addr];
    end

endmodule

// File: sv/stereo_peak_compressor_mix.sv
// top level: stereo feed-forward peak compressor with dry/wet blend and output gain
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        wet_left, wet_right, dry_left, dry_right
//  m_axis    out        m_axis_tvalid/tready        out_left, out_right
//  apb       in         psel/penable/pwrite/pready  7 config registers at 4*index
//
// one frame at a time through a small sequencer around a single multiply-accumulate
// unit; a frame above threshold runs the log, reduction and exp states, one at or
// below threshold skips them, and with compression off only the blend and output
// gain states run; table reads, the hand-over and the accept are states of their own
// reset (synchronous, active low) clears the envelope, sequencer and config registers
// the finished frame sits in an output register, so the next input transfer is
// taken while that result waits; only the hand-over into the output register
// waits on m_axis_tready
module stereo_peak_compressor_mix import spc_pkg::*; #(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // apb configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [CFG_AW-1:0]                     paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // wet_left, wet_right, dry_left, dry_right (lowest bits first), zero pad
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_left, out_right (lowest bits first), zero pad
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int TIB    = TABLE_INDEX_BITS;
    localparam int WX     = W + 3;              // scaled wet and blended samples
    localparam int ENV_W  = W - 1;
    localparam int A_W    = mac_a_width(W);
    localparam int ACC_W  = mac_acc_width(W);
    localparam int OUT_TW = ((2*W+7)/8)*8;
    localparam int YW     = ACC_W - 20;

    localparam logic [WX-1:0] ENV_MAX_X = {4'd0, {ENV_W{1'b1}}};

    // config
    t_cfg cfg;

    spc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    t_state r_state;
    t_state n_state;
    logic   r_ch;                 // 0 left, 1 right

    // frame and envelope registers
    logic signed [WX-1:0] r_wet [2];
    logic signed [W-1:0]  r_dry [2];
    logic        [W-1:0]  r_res [2];
    logic [ENV_W-1:0]     r_env;
    logic [ENV_W-1:0]     r_peak;
    logic [23:0]          r_coef;
    logic [4:0]           r_p;
    logic [19:0]          r_lg;
    logic [3:0]           r_n;
    logic [15:0]          r_f;
    logic [22:0]          r_g;
    logic [23:0]          r_tg;
    logic signed [WX-1:0] r_x;
    logic                 r_ovalid;
    logic [W-1:0]         r_out_l;
    logic [W-1:0]         r_out_r;

    // mac
    t_mac_ctl           mac_ctl;
    logic [A_W-1:0]     mac_a;
    logic [MAC_B_W-1:0] mac_b;
    logic [ACC_W-1:0]   acc;

    spc_mac #(
        .SAMPLE_WIDTH (W)
    ) u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    // tables
    logic [TIB-1:0] log_addr;
    logic [TIB-1:0] exp_addr;
    logic [15:0]    log_q;
    logic [15:0]    exp_q;

    spc_rom #(
        .TABLE_INDEX_BITS (TIB)
    ) u_rom (
        .i_clk      (i_clk),
        .i_log_addr (log_addr),
        .i_exp_addr (exp_addr),
        .o_log_q    (log_q),
        .o_exp_q    (exp_q)
    );

    // derived values
    logic              in_xfer;
    logic              out_load;
    logic [WX-1:0]     mag_l;
    logic [WX-1:0]     mag_r;
    logic [WX-1:0]     mag_max;
    logic [ENV_W-1:0]  peak;
    logic [31:0]       env32;
    logic              above;
    logic [4:0]        msb_pos;
    logic [4:0]        idx_shift;
    logic [4:0]        p_off;
    logic [16:0]       exp_arg;
    logic [4:0]        n_plus1;
    logic [22:0]       gain;
    logic [16:0]       mix_sat;
    logic [16:0]       mix_inv;
    logic [YW-1:0]     y_out;
    logic              y_ovf;
    logic [W-1:0]      y_sat;

    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);

    // peak of the wet pair, clamped to the envelope range
    assign mag_l   = r_wet[0][WX-1] ? WX'(-r_wet[0]) : WX'(r_wet[0]);
    assign mag_r   = r_wet[1][WX-1] ? WX'(-r_wet[1]) : WX'(r_wet[1]);
    assign mag_max = (mag_l > mag_r) ? mag_l : mag_r;
    assign peak    = (mag_max > ENV_MAX_X) ? ENV_MAX_X[ENV_W-1:0] : mag_max[ENV_W-1:0];

    // msb of the envelope and the table index below it
    assign env32 = {{(32-ENV_W){1'b0}}, r_env};
    assign above = env32 > THRESH_LEVEL;

    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (env32[i]) begin
                msb_pos = 5'(i);
            end
        end
    end

    assign idx_shift = r_p - 5'(TIB);
    assign log_addr  = TIB'(env32 >> idx_shift);
    assign p_off     = r_p - 5'(THRESH_LOG);

    // exp2 index from the fraction complement
    assign exp_arg  = 17'd65536 - {1'b0, r_f};
    assign exp_addr = exp_arg[16-TIB +: TIB];
    assign n_plus1  = {1'b0, r_n} + 5'd1;
    assign gain     = (r_f == 16'd0) ? (23'h400000 >> r_n)
                                     : ({1'b1, exp_q, 6'd0} >> n_plus1);

    assign mix_sat = (cfg.dry_wet_mix > 17'd65536) ? 17'd65536 : cfg.dry_wet_mix;
    assign mix_inv = 17'd65536 - mix_sat;

    // output gain result, saturated to the sample width
    assign y_out = acc[ACC_W-1:20];
    assign y_ovf = y_out[YW-1:W-1] != {(YW-W+1){y_out[YW-1]}};
    assign y_sat = y_ovf ? (y_out[YW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                         : y_out[W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = cfg.comp_enable ? S_PEAK : S_MIX_A;
                end
            end
            S_PEAK:    n_state = S_ENV_A;
            S_ENV_A:   n_state = S_ENV_B;
            S_ENV_B:   n_state = S_ENV_WB;
            S_ENV_WB:  n_state = S_NORM;
            S_NORM:    n_state = above ? S_LOG_RD : S_TG_MUL;
            S_LOG_RD:  n_state = S_LOG_SUM;
            S_LOG_SUM: n_state = S_RED_MUL;
            S_RED_MUL: n_state = S_RED_WB;
            S_RED_WB:  n_state = S_EXP_RD;
            S_EXP_RD:  n_state = S_GAIN;
            S_GAIN:    n_state = S_TG_MUL;
            S_TG_MUL:  n_state = S_TG_WB;
            S_TG_WB:   n_state = S_SCL_MUL;
            S_SCL_MUL: n_state = S_SCL_WB;
            S_SCL_WB:  n_state = r_ch ? S_MIX_A : S_SCL_MUL;
            S_MIX_A:   n_state = S_MIX_B;
            S_MIX_B:   n_state = S_MIX_WB;
            S_MIX_WB:  n_state = S_OG_MUL;
            S_OG_MUL:  n_state = S_OG_WB;
            S_OG_WB:   n_state = r_ch ? S_DONE : S_MIX_A;
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and mac operand selection
    always_comb begin
        s_axis_tready    = 1'b0;
        mac_ctl.en       = 1'b0;
        mac_ctl.load     = 1'b0;
        mac_ctl.bias_pos = '0;
        mac_a            = '0;
        mac_b            = '0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_ENV_A: begin
                // c*env + half lsb
                mac_ctl = '{en: 1'b1, load: 1'b1, bias_pos: 5'd23};
                mac_a   = {{(A_W-ENV_W){1'b0}}, r_env};
                mac_b   = {1'b0, r_coef};
            end
            S_ENV_B: begin
                // + (1-c)*peak
                mac_ctl = '{en: 1'b1, load: 1'b0, bias_pos: 5'd0};
                mac_a   = {{(A_W-ENV_W){1'b0}}, r_peak};
                mac_b   = 25'h1000000 - {1'b0, r_coef};
            end
            S_RED_MUL: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias_pos: 5'd15};
                mac_a   = {{(A_W-20){1'b0}}, r_lg};
                mac_b   = {9'd0, cfg.comp_slope};
            end
            S_TG_MUL: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias_pos: 5'd21};
                mac_a   = {{(A_W-23){1'b0}}, r_g};
                mac_b   = {1'b0, cfg.makeup_gain};
            end
            S_SCL_MUL: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias_pos: 5'd21};
                mac_a   = {{(A_W-WX){r_wet[r_ch][WX-1]}}, r_wet[r_ch]};
                mac_b   = {1'b0, r_tg};
            end
            S_MIX_A: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias_pos: 5'd15};
                mac_a   = {{(A_W-W){r_dry[r_ch][W-1]}}, r_dry[r_ch]};
                mac_b   = {8'd0, mix_inv};
            end
            S_MIX_B: begin
                mac_ctl = '{en: 1'b1, load: 1'b0, bias_pos: 5'd0};
                mac_a   = {{(A_W-WX){r_wet[r_ch][WX-1]}}, r_wet[r_ch]};
                mac_b   = {8'd0, mix_sat};
            end
            S_OG_MUL: begin
                mac_ctl = '{en: 1'b1, load: 1'b1, bias_pos: 5'd19};
                mac_a   = {{(A_W-WX){r_x[WX-1]}}, r_x};
                mac_b   = {1'b0, cfg.output_gain};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= 1'b0;
            r_env    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_SCL_WB) || (r_state == S_OG_WB)) begin
                r_ch <= ~r_ch;
            end
            if (r_state == S_ENV_WB) begin
                r_env <= acc[24 +: ENV_W];
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_wet[0] <= WX'($signed(s_axis_tdata[0 +: W]));
                    r_wet[1] <= WX'($signed(s_axis_tdata[W +: W]));
                    r_dry[0] <= s_axis_tdata[2*W +: W];
                    r_dry[1] <= s_axis_tdata[3*W +: W];
                end
            end
            S_PEAK: begin
                // attack while the peak rises over the envelope
                r_peak <= peak;
                r_coef <= (peak > r_env) ? cfg.attack_coeff : cfg.release_coeff;
            end
            S_NORM: begin
                r_p <= msb_pos;
                r_g <= 23'h400000;      // unity until the curve says otherwise
            end
            S_LOG_SUM: r_lg <= {p_off[3:0], log_q};
            S_RED_WB: begin
                r_n <= acc[32 +: 4];
                r_f <= acc[16 +: 16];
            end
            S_GAIN:   r_g  <= gain;
            S_TG_WB:  r_tg <= acc[22 +: 24];
            S_SCL_WB: r_wet[r_ch] <= acc[22 +: WX];
            S_MIX_WB: r_x <= acc[16 +: WX];
            S_OG_WB:  r_res[r_ch] <= y_sat;
            default: ;
        endcase
        if (out_load) begin
            r_out_l <= r_res[0];
            r_out_r <= r_res[1];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_TW'({r_out_r, r_out_l});

endmodule

// File: test/stereo_peak_compressor_mix_tb.sv
// self-checking testbench for the stereo peak compressor with dry/wet blend
module stereo_peak_compressor_mix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int     SW         = SAMPLE_WIDTH_DEF;
    localparam int     TIB        = TABLE_INDEX_BITS_DEF;
    localparam int     CURVE_LEN  = 1 << TIB;
    localparam int     S_BITS     = ((4 * SW + 7) / 8) * 8;
    localparam int     M_BITS     = ((2 * SW + 7) / 8) * 8;
    localparam longint SAMPLE_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint THRESH_ENV = longint'(1) << THRESH_LOG;

    // register ranges used for the stimulus
    localparam int SLOPE_MAX  = 62259;
    localparam int MAKEUP_MIN = 4194304;
    localparam int MAKEUP_MAX = 13263360;
    localparam int COEFF_MAX  = 16777215;
    localparam int MIX_FULL   = 65536;
    localparam int MIX_TOP    = 131071;
    localparam int GAIN_MIN   = 1048576;
    localparam int GAIN_MAX   = 16618870;

    // the settle time covers the slowest frame plus an idle gap on each side
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MAX_PRINTED     = 100;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 110;

    // packed so that wet_left lands in the lowest bits of tdata
    typedef struct packed {
        logic [SW-1:0] dry_right;
        logic [SW-1:0] dry_left;
        logic [SW-1:0] wet_right;
        logic [SW-1:0] wet_left;
    } t_frame;

    typedef struct packed {
        logic [SW-1:0] out_right;
        logic [SW-1:0] out_left;
    } t_result;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [CFG_AW-1:0] paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // wet_left, wet_right, dry_left, dry_right (lowest bits first), zero pad
    logic [S_BITS-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // out_left, out_right (lowest bits first), zero pad
    logic [M_BITS-1:0] m_axis_tdata;

    // shadow of the register file and the envelope follower
    t_cfg        cfg_shadow;
    longint      env_level;
    logic [15:0] log_curve [CURVE_LEN];
    logic [15:0] exp_curve [CURVE_LEN];

    t_frame  pending_frames[$];
    t_result expected_outputs[$];
    t_frame  tx_frame;
    int      tx_wait;
    int      rx_wait;
    bit      tx_idle_on;
    bit      rx_idle_on;
    int      rx_count;
    int      mismatch_count;
    int      idle_cycles;

    stereo_peak_compressor_mix u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // log2 fraction of a q1.16 mantissa in [1,2): square, and every pass
    // over 2 yields a one bit and a halving
    function automatic logic [15:0] frac_log2(input logic [16:0] mant);
        logic [63:0] sq;
        logic [15:0] bits_out;
        sq       = 64'(mant) << 14;
        bits_out = '0;
        repeat (16) begin
            sq       = (sq * sq) >> 30;
            bits_out = bits_out << 1;
            if (sq >= (64'd1 << 31)) begin
                bits_out[0] = 1'b1;
                sq          = sq >> 1;
            end
        end
        return bits_out;
    endfunction

    // log points are sampled mantissas; exp points invert the same curve
    task automatic build_curves();
        int lo;
        int hi;
        int mid;
        int pt;
        for (int i = 0; i < CURVE_LEN; i++) begin
            pt           = i << (16 - TIB);
            log_curve[i] = frac_log2(17'(65536 + pt));
            lo           = 65536;
            hi           = 131071;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (int'(frac_log2(17'(mid))) <= pt) lo = mid;
                else hi = mid - 1;
            end
            exp_curve[i] = 16'(lo - 65536);
        end
    endtask

    function automatic longint clip(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    // one frame through follower, gain computer (if enabled), blend and output gain
    function automatic t_result compute_mix(input t_frame f);
        longint  wl, wr, dl, dr, mag_l, mag_r, pk, coef;
        longint  gain, total, lg, red, fr, mix, ol, orr;
        int      msb;
        int      nsh;
        int      idx;
        t_result res;
        wl = longint'($signed(f.wet_left));
        wr = longint'($signed(f.wet_right));
        dl = longint'($signed(f.dry_left));
        dr = longint'($signed(f.dry_right));
        if (cfg_shadow.comp_enable) begin
            mag_l = (wl < 0) ? -wl : wl;
            mag_r = (wr < 0) ? -wr : wr;
            pk    = (mag_l > mag_r) ? mag_l : mag_r;
            // a full-scale negative sample clamps to the envelope ceiling
            if (pk > SAMPLE_MAX) pk = SAMPLE_MAX;
            coef = (pk > env_level) ? longint'(cfg_shadow.attack_coeff)
                                    : longint'(cfg_shadow.release_coeff);
            env_level = (coef * env_level + ((longint'(1) << 24) - coef) * pk
                         + (longint'(1) << 23)) >>> 24;
            gain = longint'(1) << 22;
            if (env_level > THRESH_ENV) begin
                msb = THRESH_LOG;
                while ((env_level >> (msb + 1)) != 0) msb++;
                idx = int'((env_level >> (msb - TIB)) % CURVE_LEN);
                lg  = (longint'(msb - THRESH_LOG) << 16) + longint'(log_curve[idx]);
                red = (lg * longint'(cfg_shadow.comp_slope) + 32768) >>> 16;
                nsh = int'(red >>> 16);
                if (nsh > 40) nsh = 40;
                fr = red % 65536;
                if (fr == 0) begin
                    gain = (longint'(1) << 22) >>> nsh;
                end else begin
                    idx  = int'((65536 - fr) >>> (16 - TIB));
                    gain = ((65536 + longint'(exp_curve[idx])) << 6) >>> (nsh + 1);
                end
            end
            total = (gain * longint'(cfg_shadow.makeup_gain) + (1 << 21)) >>> 22;
            wl    = (wl * total + (1 << 21)) >>> 22;
            wr    = (wr * total + (1 << 21)) >>> 22;
        end
        // a wet share above one acts as all wet
        mix = longint'(cfg_shadow.dry_wet_mix);
        if (mix > MIX_FULL) mix = MIX_FULL;
        ol  = ((MIX_FULL - mix) * dl + mix * wl + 32768) >>> 16;
        orr = ((MIX_FULL - mix) * dr + mix * wr + 32768) >>> 16;
        ol  = clip((ol * longint'(cfg_shadow.output_gain) + (1 << 19)) >>> 20);
        orr = clip((orr * longint'(cfg_shadow.output_gain) + (1 << 19)) >>> 20);
        res.out_left  = SW'(ol);
        res.out_right = SW'(orr);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        // keep the log short when something goes badly wrong
        if (mismatch_count < MAX_PRINTED) $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [M_BITS-1:0] data);
        t_result       want;
        logic [SW-1:0] got_l;
        logic [SW-1:0] got_r;
        got_l = data[SW-1:0];
        got_r = data[2*SW-1:SW];
        if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", rx_count));
        end else begin
            want = expected_outputs.pop_front();
            if (got_l !== want.out_left)
                report_mismatch($sformatf("result %0d out_left got %h want %h",
                                          rx_count, got_l, want.out_left));
            if (got_r !== want.out_right)
                report_mismatch($sformatf("result %0d out_right got %h want %h",
                                          rx_count, got_r, want.out_right));
        end
        rx_count++;
    endtask

    // ------------------------------------------------------------------
    // input driver: presents queued frames, predicts each at its transfer,
    // then idles a drawn number of cycles before the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outputs = {expected_outputs, compute_mix(tx_frame)};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    tx_frame = pending_frames.pop_front();
                    s_axis_tdata  <= S_BITS'(tx_frame);
                    s_axis_tvalid <= 1'b1;
                    tx_wait = tx_idle_on ? $urandom_range(5, 0) : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: checks each transfer and stalls a drawn number of
    // cycles after it
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                rx_wait = rx_idle_on ? $urandom_range(5, 0) : 0;
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: any transfer on either stream or the register port counts
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // register port and sequencing helpers
    // ------------------------------------------------------------------

    // setup then access; the register takes the value at the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COMP_ENABLE:   cfg_shadow.comp_enable   = value[0];
            REG_COMP_SLOPE:    cfg_shadow.comp_slope    = value[15:0];
            REG_MAKEUP_GAIN:   cfg_shadow.makeup_gain   = value[23:0];
            REG_ATTACK_COEFF:  cfg_shadow.attack_coeff  = value[23:0];
            REG_RELEASE_COEFF: cfg_shadow.release_coeff = value[23:0];
            REG_DRY_WET_MIX:   cfg_shadow.dry_wet_mix   = value[16:0];
            REG_OUTPUT_GAIN:   cfg_shadow.output_gain   = value[23:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic en, input int slope, input int makeup,
                             input int attack, input int rel, input int mix,
                             input int og);
        write_reg(REG_COMP_ENABLE, 32'(en));
        write_reg(REG_COMP_SLOPE, slope);
        write_reg(REG_MAKEUP_GAIN, makeup);
        write_reg(REG_ATTACK_COEFF, attack);
        write_reg(REG_RELEASE_COEFF, rel);
        write_reg(REG_DRY_WET_MIX, mix);
        write_reg(REG_OUTPUT_GAIN, og);
    endtask

    task automatic push_frame(input longint wl, input longint wr,
                              input longint dl, input longint dr);
        t_frame f;
        f.wet_left  = SW'(wl);
        f.wet_right = SW'(wr);
        f.dry_left  = SW'(dl);
        f.dry_right = SW'(dr);
        pending_frames = {pending_frames, f};
    endtask

    // wait until every queued frame has been taken and answered
    task automatic drain();
        do @(negedge i_clk);
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
    endtask

    function automatic int pick_coeff();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return COEFF_MAX;
            2:       return $urandom_range(COEFF_MAX, COEFF_MAX - 'h40000);
            default: return $urandom_range(COEFF_MAX, 0);
        endcase
    endfunction

    function automatic int pick_range(input int lo, input int hi);
        case ($urandom_range(3, 0))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // magnitudes below 2^level, now and then full-scale or fully random
    function automatic longint rand_sample(input int level);
        longint mag;
        case ($urandom_range(19, 0))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return longint'($urandom);
            default: begin
                mag = $urandom_range((1 << level) - 1, 0);
                return $urandom_range(1, 0) ? -mag : mag;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int level;
        cfg_shadow.comp_enable   = 1'b0;
        cfg_shadow.comp_slope    = RST_COMP_SLOPE;
        cfg_shadow.makeup_gain   = RST_MAKEUP_GAIN;
        cfg_shadow.attack_coeff  = RST_ATTACK_COEFF;
        cfg_shadow.release_coeff = RST_RELEASE_COEFF;
        cfg_shadow.dry_wet_mix   = RST_DRY_WET_MIX;
        cfg_shadow.output_gain   = RST_OUTPUT_GAIN;
        env_level      = 0;
        rx_count       = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        build_curves();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: bypass, all wet, unity output, so wet passes through
        push_frame(0, 0, 0, 0);
        push_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
        push_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
        push_frame('h555555, 'hAAAAAA, 'hAAAAAA, 'h555555);
        drain();

        // hardest ratio, loudest makeup, instant poles so the envelope is the peak
        write_all(1'b1, SLOPE_MAX, MAKEUP_MAX, 0, 0, MIX_FULL, GAIN_MIN);
        push_frame(THRESH_ENV, 0, 0, 0);              // exactly at threshold
        push_frame(THRESH_ENV + 1, -5, 1, 1);         // just above
        push_frame(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MIN);
        push_frame(0, SAMPLE_MIN, 0, 0);              // full-scale negative peak
        push_frame(1000, -1000, SAMPLE_MIN, SAMPLE_MAX);
        push_frame(-(1 << 20), 1 << 19, 7, -7);
        drain();

        // bypass holds the envelope; all dry at maximum output gain saturates
        write_all(1'b0, SLOPE_MAX, MAKEUP_MAX, 16000000, int'(RST_RELEASE_COEFF), 0,
                  GAIN_MAX);
        push_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
        push_frame(123456, -654321, -1, 1);
        push_frame(SAMPLE_MIN, SAMPLE_MIN, THRESH_ENV, -THRESH_ENV);
        drain();

        // held envelope now releases; zero slope gives a whole-power gain,
        // and a wet share above one must act as all wet
        write_all(1'b1, 0, MAKEUP_MIN, COEFF_MAX, int'(RST_RELEASE_COEFF), MIX_TOP,
                  GAIN_MIN);
        push_frame(0, 0, SAMPLE_MAX, SAMPLE_MAX);
        push_frame(1 << 19, 1 << 19, 0, 0);
        push_frame(-3, 3, 0, 0);
        drain();

        // random phases: fresh settings each time, loudness changes in runs
        // of 16 frames so the follower sees both attack and release
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_all($urandom_range(3, 0) != 0,
                      pick_range(0, SLOPE_MAX),
                      pick_range(MAKEUP_MIN, MAKEUP_MAX),
                      pick_coeff(),
                      pick_coeff(),
                      ($urandom_range(4, 0) == 0) ? $urandom_range(MIX_TOP, MIX_FULL + 1)
                                                  : pick_range(0, MIX_FULL),
                      pick_range(GAIN_MIN, GAIN_MAX));
            @(negedge i_clk);
            tx_idle_on = (ph % 4 == 1) || (ph % 4 == 2);
            rx_idle_on = (ph % 4 == 1) || (ph % 4 == 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 16 == 0) level = $urandom_range(SW - 1, 8);
                push_frame(rand_sample(level), rand_sample(level),
                           rand_sample(SW - 1), rand_sample(SW - 1));
            end
            drain();
        end

        // let anything stray show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/spc_pkg.sv
sv/spc_regs.sv
sv/spc_mac.sv
sv/spc_rom.sv
sv/stereo_peak_compressor_mix.sv
test/stereo_peak_compressor_mix_tb.sv
